// File: hw/rtl/srie_pkg.sv
// shared types and opcode constants for the instruction execute block
`timescale 1ns / 1ps
package srie_pkg;

	localparam int NUM_GPR  = 16;
	localparam int GPR_AW   = 4;
	localparam int IMM_W    = 12;
	localparam int WORD_W   = 32;
	localparam int RETI_IO  = 7;

	// opcodes
	localparam logic [7:0] OP_ADD  = 8'd0;
	localparam logic [7:0] OP_SUB  = 8'd1;
	localparam logic [7:0] OP_MAC  = 8'd2;
	localparam logic [7:0] OP_AND  = 8'd3;
	localparam logic [7:0] OP_OR   = 8'd4;
	localparam logic [7:0] OP_XOR  = 8'd5;
	localparam logic [7:0] OP_SLL  = 8'd6;
	localparam logic [7:0] OP_SRA  = 8'd7;
	localparam logic [7:0] OP_SRL  = 8'd8;
	localparam logic [7:0] OP_BEQ  = 8'd9;
	localparam logic [7:0] OP_BNE  = 8'd10;
	localparam logic [7:0] OP_BLT  = 8'd11;
	localparam logic [7:0] OP_BGT  = 8'd12;
	localparam logic [7:0] OP_BLE  = 8'd13;
	localparam logic [7:0] OP_BGE  = 8'd14;
	localparam logic [7:0] OP_JAL  = 8'd15;
	localparam logic [7:0] OP_LW   = 8'd16;
	localparam logic [7:0] OP_SW   = 8'd17;
	localparam logic [7:0] OP_RETI = 8'd18;
	localparam logic [7:0] OP_IN   = 8'd19;
	localparam logic [7:0] OP_OUT  = 8'd20;
	localparam logic [7:0] OP_HALT = 8'd21;

	// class bits set by the front
	typedef struct packed {
		logic is_lw;
		logic is_mac;
	} cls_t;

	// one decoded instruction
	typedef struct packed {
		logic [7:0]        cmd;
		logic [GPR_AW-1:0] rd;
		logic [GPR_AW-1:0] rs;
		logic [GPR_AW-1:0] rt;
		logic [GPR_AW-1:0] rm;
		logic [IMM_W-1:0]  imm1;
		logic [IMM_W-1:0]  imm2;
		cls_t              cls;
	} item_t;

	// queue head as seen by the back
	typedef struct packed {
		logic  vld;
		item_t item;
	} qhead_t;

endpackage

// File: hw/rtl/srie_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module srie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/srie_front.sv
// front: input handshake, classification and two entry queue
`timescale 1ns / 1ps
module srie_front
	import srie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        cmd,
	input  logic [GPR_AW-1:0] rd,
	input  logic [GPR_AW-1:0] rs,
	input  logic [GPR_AW-1:0] rt,
	input  logic [GPR_AW-1:0] rm,
	input  logic [IMM_W-1:0]  imm_first,
	input  logic [IMM_W-1:0]  imm_second,
	input  logic              blocked,
	output qhead_t            head,
	input  logic              pop
);

	item_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	item_t      dec;
	logic       push;

	// classify the incoming instruction
	always_comb begin
		dec.cmd        = cmd;
		dec.rd         = rd;
		dec.rs         = rs;
		dec.rt         = rt;
		dec.rm         = rm;
		dec.imm1       = imm_first;
		dec.imm2       = imm_second;
		dec.cls.is_lw  = (cmd == OP_LW);
		dec.cls.is_mac = (cmd == OP_MAC);
	end

	assign in_ready = (cnt_q != 2'd2) && !blocked;
	assign push     = in_valid && in_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head.vld  = (cnt_q != 2'd0);
	assign head.item = ent_q[rp_q];

endmodule

// File: hw/rtl/srie_back.sv
// back: register and memory state, execution and result register
`timescale 1ns / 1ps
module srie_back
	import srie_pkg::*;
#(
	parameter int MEM_WORDS = 1024,
	parameter int NUM_IO    = 23,
	parameter int PC_BITS   = 12,
	localparam int AW       = $clog2(MEM_WORDS),
	localparam int IOW      = $clog2(NUM_IO)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qhead_t                   head,
	output logic                     pop,
	output logic                     clearing,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PC_BITS-1:0]       next_pc,
	output logic                     halted,
	output logic                     reg_write,
	output logic [GPR_AW-1:0]        reg_index,
	output logic signed [WORD_W-1:0] reg_value,
	output logic                     mem_write,
	output logic [AW-1:0]            mem_addr,
	output logic signed [WORD_W-1:0] mem_value,
	output logic                     io_error
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EX   = 3'd2;
	localparam logic [2:0] ST_LD   = 3'd3;
	localparam logic [2:0] ST_MAC  = 3'd4;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_cnt_q;
	item_t              cur_q;
	logic [NUM_GPR-1:0] gvld_q;
	logic [WORD_W-1:0]  io_q [NUM_IO];
	logic [PC_BITS-1:0] pc_q;
	logic               halt_q;
	logic [WORD_W-1:0]  prod_q;

	logic [WORD_W-1:0]  rdat_a, rdat_b, rdat_c, rdat_d, dm_rdata;
	logic [WORD_W-1:0]  a, b, c, d, sum_ab;
	logic [AW-1:0]      addr;
	logic               in_rng;
	logic [PC_BITS-1:0] npc, target, nxt_pc;
	logic               jump, set_halt, io_we;
	logic               r_wr, r_mw, r_ioerr;
	logic [WORD_W-1:0]  r_wv, r_mv;
	logic [AW-1:0]      r_maddr;
	logic               out_free, need_more, fin, rd_issue;
	logic               gpr_we, dm_we, dm_re;
	logic [AW-1:0]      dm_waddr;
	logic [WORD_W-1:0]  dm_wdata;

	assign clearing = (state_q == ST_CLR);
	assign rd_issue = (state_q == ST_IDLE) && head.vld;
	assign pop      = rd_issue;

	// four copies of the register file, one per operand
	srie_ram #(.WIDTH(WORD_W), .DEPTH(NUM_GPR)) u_gpr_a (
		.clk(clk), .we(gpr_we), .waddr(cur_q.rd), .wdata(r_wv),
		.re(rd_issue), .raddr(head.item.rs), .rdata(rdat_a)
	);
	srie_ram #(.WIDTH(WORD_W), .DEPTH(NUM_GPR)) u_gpr_b (
		.clk(clk), .we(gpr_we), .waddr(cur_q.rd), .wdata(r_wv),
		.re(rd_issue), .raddr(head.item.rt), .rdata(rdat_b)
	);
	srie_ram #(.WIDTH(WORD_W), .DEPTH(NUM_GPR)) u_gpr_c (
		.clk(clk), .we(gpr_we), .waddr(cur_q.rd), .wdata(r_wv),
		.re(rd_issue), .raddr(head.item.rm), .rdata(rdat_c)
	);
	srie_ram #(.WIDTH(WORD_W), .DEPTH(NUM_GPR)) u_gpr_d (
		.clk(clk), .we(gpr_we), .waddr(cur_q.rd), .wdata(r_wv),
		.re(rd_issue), .raddr(head.item.rd), .rdata(rdat_d)
	);

	// data memory
	srie_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.re(dm_re), .raddr(addr), .rdata(dm_rdata)
	);

	// operand select: registers one and two always hold this item's immediates
	function automatic logic [WORD_W-1:0] opnd(
		input logic [GPR_AW-1:0] idx,
		input logic [WORD_W-1:0] rdat,
		input logic [NUM_GPR-1:0] vld,
		input logic [IMM_W-1:0]  i1,
		input logic [IMM_W-1:0]  i2
	);
		logic [WORD_W-1:0] v;
		if (idx == GPR_AW'(1)) begin
			v = WORD_W'(i1);
		end else if (idx == GPR_AW'(2)) begin
			v = WORD_W'(i2);
		end else if (vld[idx]) begin
			v = rdat;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	// execute
	always_comb begin
		a      = opnd(cur_q.rs, rdat_a, gvld_q, cur_q.imm1, cur_q.imm2);
		b      = opnd(cur_q.rt, rdat_b, gvld_q, cur_q.imm1, cur_q.imm2);
		c      = opnd(cur_q.rm, rdat_c, gvld_q, cur_q.imm1, cur_q.imm2);
		d      = opnd(cur_q.rd, rdat_d, gvld_q, cur_q.imm1, cur_q.imm2);
		sum_ab = a + b;
		addr   = sum_ab[AW-1:0];
		in_rng = (sum_ab < WORD_W'(NUM_IO));
		npc    = pc_q + PC_BITS'(1);
		target = c[PC_BITS-1:0];
		jump     = 1'b0;
		set_halt = 1'b0;
		io_we    = 1'b0;
		r_wr     = 1'b0;
		r_wv     = '0;
		r_mw     = 1'b0;
		r_mv     = '0;
		r_maddr  = '0;
		r_ioerr  = 1'b0;
		case (cur_q.cmd)
			OP_ADD: begin r_wr = 1'b1; r_wv = a + b + c; end
			OP_SUB: begin r_wr = 1'b1; r_wv = a - b - c; end
			OP_MAC: begin r_wr = 1'b1; r_wv = prod_q + c; end
			OP_AND: begin r_wr = 1'b1; r_wv = a & b & c; end
			OP_OR:  begin r_wr = 1'b1; r_wv = a | b | c; end
			OP_XOR: begin r_wr = 1'b1; r_wv = a ^ b ^ c; end
			OP_SLL: begin r_wr = 1'b1; r_wv = a << b[4:0]; end
			OP_SRA: begin r_wr = 1'b1; r_wv = WORD_W'($signed(a) >>> b[4:0]); end
			OP_SRL: begin r_wr = 1'b1; r_wv = a >> b[4:0]; end
			OP_BEQ: jump = (a == b);
			OP_BNE: jump = (a != b);
			OP_BLT: jump = ($signed(a) < $signed(b));
			OP_BGT: jump = ($signed(b) < $signed(a));
			OP_BLE: jump = !($signed(b) < $signed(a));
			OP_BGE: jump = !($signed(a) < $signed(b));
			OP_JAL: begin r_wr = 1'b1; r_wv = WORD_W'(npc); jump = 1'b1; end
			OP_LW: begin r_wr = 1'b1; r_wv = dm_rdata + c; r_maddr = addr; end
			OP_SW: begin r_mw = 1'b1; r_mv = c + d; r_maddr = addr; end
			OP_RETI: begin jump = 1'b1; target = io_q[RETI_IO][PC_BITS-1:0]; end
			OP_IN: begin
				if (in_rng) begin
					r_wr = 1'b1;
					r_wv = io_q[sum_ab[IOW-1:0]];
				end else begin
					r_ioerr = 1'b1;
				end
			end
			OP_OUT: begin
				if (in_rng) begin
					io_we = 1'b1;
				end else begin
					r_ioerr = 1'b1;
				end
			end
			OP_HALT: set_halt = 1'b1;
			default: ;
		endcase
		// a halted core ignores everything
		if (halt_q) begin
			jump     = 1'b0;
			set_halt = 1'b0;
			io_we    = 1'b0;
			r_wr     = 1'b0;
			r_wv     = '0;
			r_mw     = 1'b0;
			r_mv     = '0;
			r_maddr  = '0;
			r_ioerr  = 1'b0;
		end
		nxt_pc = halt_q ? pc_q : (jump ? target : npc);
	end

	// sequencing of the current instruction
	assign out_free  = !out_valid || out_ready;
	assign need_more = !halt_q && (cur_q.cls.is_lw || cur_q.cls.is_mac);
	assign fin       = out_free && (((state_q == ST_EX) && !need_more) ||
	                   (state_q == ST_LD) || (state_q == ST_MAC));
	assign gpr_we    = fin && r_wr;
	assign dm_re     = (state_q == ST_EX) && !halt_q && cur_q.cls.is_lw;
	assign dm_we     = clearing || (fin && r_mw);
	assign dm_waddr  = clearing ? clr_cnt_q : r_maddr;
	assign dm_wdata  = clearing ? '0 : r_mv;

	// state machine and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			gvld_q    <= '0;
			pc_q      <= '0;
			halt_q    <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_IO; i++) begin
				io_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.vld) begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					if (need_more) begin
						state_q <= cur_q.cls.is_lw ? ST_LD : ST_MAC;
					end else if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LD, ST_MAC: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin) begin
				out_valid <= 1'b1;
				pc_q      <= nxt_pc;
				if (set_halt) begin
					halt_q <= 1'b1;
				end
				if (r_wr) begin
					gvld_q[cur_q.rd] <= 1'b1;
				end
				if (io_we) begin
					io_q[sum_ab[IOW-1:0]] <= c;
				end
			end
		end
	end

	// instruction and product holding, result payload
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			cur_q <= head.item;
		end
		if (state_q == ST_EX) begin
			prod_q <= a * b;
		end
		if (fin) begin
			next_pc   <= nxt_pc;
			halted    <= halt_q || set_halt;
			reg_write <= r_wr;
			reg_index <= r_wr ? cur_q.rd : '0;
			reg_value <= r_wv;
			mem_write <= r_mw;
			mem_addr  <= r_maddr;
			mem_value <= r_mv;
			io_error  <= r_ioerr;
		end
	end

	// no instruction leaves the queue during the clearing pass
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("instruction taken during memory clear");

	// a result is only loaded when the output register is free
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_valid || out_ready))
		else $error("result overwrote pending transaction");

	// halt is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// a halted core writes no state
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && halt_q) |-> (!gpr_we && !dm_we && !io_we))
		else $error("state written while halted");

endmodule

// File: hw/rtl/simple_risc_instruction_execute.sv
// top level of the instruction execute block
// Executes one decoded instruction per input transaction and returns one
// result transaction per instruction, in order.
// Input channel: in_valid/in_ready with cmd, rd, rs, rt, rm, imm_first and
// imm_second. Output channel: out_valid/out_ready with next_pc, halted,
// reg_write, reg_index, reg_value, mem_write, mem_addr, mem_value, io_error.
// A two entry queue sits between the input handshake and the execute side,
// so the input keeps accepting while the execute side works or is stalled, until the queue is full.
// Each instruction is a register file read, then execute and write back;
// lw adds a data memory read and mac a registered multiply before the add.
// The execute side finishes one instruction before it takes the next one
// from the queue; the result is registered before out_valid rises.
// Reset: registers, I/O registers, PC and halt flag clear at once; the data
// memory is then cleared one word a cycle, every word from 0 to MEM_WORDS-1,
// during which in_ready is low. MEM_WORDS must be a power of two.
// A stalled output holds its result; execution waits until it is taken and
// the queue then fills and drops in_ready.
`timescale 1ns / 1ps
module simple_risc_instruction_execute
	import srie_pkg::*;
#(
	parameter int MEM_WORDS = 1024,
	parameter int NUM_IO    = 23,
	parameter int PC_BITS   = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     cmd,
	input  logic [GPR_AW-1:0]              rd,
	input  logic [GPR_AW-1:0]              rs,
	input  logic [GPR_AW-1:0]              rt,
	input  logic [GPR_AW-1:0]              rm,
	input  logic [IMM_W-1:0]               imm_first,
	input  logic [IMM_W-1:0]               imm_second,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [PC_BITS-1:0]             next_pc,
	output logic                           halted,
	output logic                           reg_write,
	output logic [GPR_AW-1:0]              reg_index,
	output logic signed [WORD_W-1:0]       reg_value,
	output logic                           mem_write,
	output logic [$clog2(MEM_WORDS)-1:0]   mem_addr,
	output logic signed [WORD_W-1:0]       mem_value,
	output logic                           io_error
);

	qhead_t head;
	logic   pop;
	logic   clearing;

	// front: accept and classify
	srie_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .rd(rd), .rs(rs), .rt(rt), .rm(rm),
		.imm_first(imm_first), .imm_second(imm_second),
		.blocked(clearing), .head(head), .pop(pop)
	);

	// back: execute
	srie_back #(.MEM_WORDS(MEM_WORDS), .NUM_IO(NUM_IO), .PC_BITS(PC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .pop(pop), .clearing(clearing),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .halted(halted),
		.reg_write(reg_write), .reg_index(reg_index), .reg_value(reg_value),
		.mem_write(mem_write), .mem_addr(mem_addr), .mem_value(mem_value),
		.io_error(io_error)
	);

endmodule
